>>> design/direct_mapped_cache_tag_check_defines.svh
// Assertion macros shared by the cache tag check modules.
`ifndef DIRECT_MAPPED_CACHE_TAG_CHECK_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_TAG_CHECK_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dmc_pkg.sv
// Shared constants and controller-to-datapath types for the cache tag check.
package dmc_pkg;

    // Default geometry; both must be powers of two.
    localparam int NUM_LINES_DEF   = 128;
    localparam int BLOCK_BYTES_DEF = 32;

    // Fixed widths of the ports.
    localparam int ADDR_W = 32;
    localparam int OFF_W  = 5;
    localparam int BLK_W  = 27;
    localparam int IDX_W  = 7;
    localparam int TAG_W  = 20;
    localparam int RDB_W  = 6;

    // Opcode encoding.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;    // write one zero line of the tag store
        logic capture;  // take the input word and start the tag read
        logic commit;   // resolve the lookup and load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // the clearing pass is at its last line
        logic out_free;    // the output register can take a word this cycle
    } t_dp_status;

endpackage

>>> design/dmc_ctrl.sv
// Controller state machine for the cache tag check.
`include "direct_mapped_cache_tag_check_defines.svh"

module dmc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dmc_pkg::t_dp_status i_status,
    output dmc_pkg::t_dp_cmd    o_cmd
);
    import dmc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_READ  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Handshake and datapath commands.
    assign o_ready       = (r_state == S_IDLE);
    assign o_cmd.clear   = (r_state == S_CLEAR);
    assign o_cmd.capture = (r_state == S_IDLE) && i_valid;
    assign o_cmd.commit  = (r_state == S_READ) && i_status.out_free;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `DMC_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_ready, "word accepted during the clearing pass")
    `DMC_ASSERT_NEXT(a_capture_to_read, i_clk, i_rst_n, o_cmd.capture, r_state == S_READ, "capture not followed by the tag read state")
    `DMC_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.clear, o_cmd.capture, o_cmd.commit}), "more than one datapath command at once")

endmodule

>>> design/dmc_datapath.sv
// Datapath of the cache tag check: address split, tag store and result register.
`include "direct_mapped_cache_tag_check_defines.svh"

module dmc_datapath #(
    parameter int NUM_LINES   = dmc_pkg::NUM_LINES_DEF,
    parameter int BLOCK_BYTES = dmc_pkg::BLOCK_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dmc_pkg::t_dp_cmd           i_cmd,
    output dmc_pkg::t_dp_status        o_status,
    input  logic [dmc_pkg::ADDR_W-1:0] i_address,
    input  logic                       i_opcode,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [dmc_pkg::OFF_W-1:0]  o_byte_offset,
    output logic [dmc_pkg::BLK_W-1:0]  o_block_number,
    output logic [dmc_pkg::IDX_W-1:0]  o_line_index,
    output logic [dmc_pkg::TAG_W-1:0]  o_address_tag,
    output logic                       o_miss,
    output logic                       o_mem_read,
    output logic [dmc_pkg::RDB_W-1:0]  o_mem_read_bytes,
    output logic                       o_mem_write,
    output logic                       o_mem_write_bytes,
    output logic                       o_replacement,
    output logic [dmc_pkg::TAG_W-1:0]  o_evicted_tag
);
    import dmc_pkg::*;

    localparam int OFF_BITS  = $clog2(BLOCK_BYTES);
    localparam int LINE_BITS = $clog2(NUM_LINES);
    localparam int STAG_W    = ADDR_W - OFF_BITS - LINE_BITS;
    localparam int WORD_W    = STAG_W + 1;
    localparam logic [LINE_BITS-1:0] LAST_LINE   = LINE_BITS'(NUM_LINES - 1);
    localparam logic [RDB_W-1:0]     FETCH_BYTES = RDB_W'(BLOCK_BYTES);

    // Tag store: each word holds the valid bit above the tag.
    logic [WORD_W-1:0]    r_mem [NUM_LINES];
    logic [WORD_W-1:0]    r_rd_word;

    logic [LINE_BITS-1:0] r_clr_idx, n_clr_idx;
    logic                 r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]    r_addr;
    logic                 r_wr;

    logic [LINE_BITS-1:0] in_line;
    logic [ADDR_W-1:0]    cur_block;
    logic [LINE_BITS-1:0] cur_line;
    logic [STAG_W-1:0]    cur_tag;
    logic [OFF_BITS-1:0]  cur_offset;
    logic                 stored_valid;
    logic [STAG_W-1:0]    stored_tag;
    logic                 hit;
    logic                 fetch;
    logic                 repl;
    logic                 is_write;

    // Address split of the incoming and the held reference.
    assign in_line    = i_address[OFF_BITS +: LINE_BITS];
    assign cur_block  = r_addr >> OFF_BITS;
    assign cur_line   = r_addr[OFF_BITS +: LINE_BITS];
    assign cur_tag    = r_addr[ADDR_W-1 -: STAG_W];
    assign cur_offset = r_addr[OFF_BITS-1:0];

    // Tag compare and write-through, no-write-allocate policy.
    assign stored_valid = r_rd_word[WORD_W-1];
    assign stored_tag   = r_rd_word[STAG_W-1:0];
    assign hit          = stored_valid && (stored_tag == cur_tag);
    assign is_write     = (r_wr == OP_WRITE);
    assign fetch        = !hit && !is_write;
    assign repl         = fetch && stored_valid;

    // Status to the controller.
    assign o_status.clear_last = (r_clr_idx == LAST_LINE);
    assign o_status.out_free   = !r_out_valid || i_ready;
    assign o_valid             = r_out_valid;

    // Tag store: one write port shared by the clearing pass and read-miss fills.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_cmd.commit && fetch) begin
            r_mem[cur_line] <= {1'b1, cur_tag};
        end
        if (i_cmd.capture) begin
            r_rd_word <= r_mem[in_line];
        end
    end

    // Next values of the control registers.
    always_comb begin
        n_clr_idx   = r_clr_idx;
        n_out_valid = r_out_valid;
        if (i_cmd.clear) begin
            n_clr_idx = r_clr_idx + 1'b1;
        end
        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Held reference and output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr <= i_address;
            r_wr   <= i_opcode;
        end
        if (i_cmd.commit) begin
            o_byte_offset     <= OFF_W'(cur_offset);
            o_block_number    <= cur_block[BLK_W-1:0];
            o_line_index      <= IDX_W'(cur_line);
            o_address_tag     <= TAG_W'(cur_tag);
            o_miss            <= !hit;
            o_mem_read        <= fetch;
            o_mem_read_bytes  <= fetch ? FETCH_BYTES : '0;
            o_mem_write       <= is_write;
            o_mem_write_bytes <= is_write;
            o_replacement     <= repl;
            o_evicted_tag     <= repl ? TAG_W'(stored_tag) : '0;
        end
    end

    `DMC_ASSERT_NEXT(a_commit_loads, i_clk, i_rst_n, i_cmd.commit, r_out_valid, "committed lookup did not reach the output register")
    `DMC_ASSERT_IMP(a_repl_is_fetch, i_clk, i_rst_n, r_out_valid && o_replacement, o_mem_read && o_miss, "replacement without a read miss fill")
    `DMC_ASSERT_IMP(a_write_no_fetch, i_clk, i_rst_n, r_out_valid && o_mem_write, !o_mem_read, "write reference fetched a block")

endmodule

>>> design/direct_mapped_cache_tag_check.sv
// Top level of the direct-mapped, write-through cache tag check.
//
//  channel | valid   | ready   | word
//  --------+---------+---------+------------------------------------------------
//  input   | i_valid | o_ready | i_address, i_opcode
//  result  | o_valid | i_ready | o_byte_offset ... o_evicted_tag (one per input)
//
// Each reference passes through two steps: accepting it and reading the tag store,
// then comparing the tag, filling the line on a read miss and loading the result.
// The registered read data of the tag store is what splits the work into these steps.
// After reset a clearing pass zeroes the tag store, one line a cycle, so no
// word is accepted until every line has been zeroed.
// A stalled result holds in the output register; the next reference is still
// accepted and waits at the compare step until the output register frees up.
// NUM_LINES and BLOCK_BYTES must be powers of two.

module direct_mapped_cache_tag_check #(
    parameter int NUM_LINES   = dmc_pkg::NUM_LINES_DEF,
    parameter int BLOCK_BYTES = dmc_pkg::BLOCK_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [dmc_pkg::ADDR_W-1:0] i_address,
    input  logic                       i_opcode,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [dmc_pkg::OFF_W-1:0]  o_byte_offset,
    output logic [dmc_pkg::BLK_W-1:0]  o_block_number,
    output logic [dmc_pkg::IDX_W-1:0]  o_line_index,
    output logic [dmc_pkg::TAG_W-1:0]  o_address_tag,
    output logic                       o_miss,
    output logic                       o_mem_read,
    output logic [dmc_pkg::RDB_W-1:0]  o_mem_read_bytes,
    output logic                       o_mem_write,
    output logic                       o_mem_write_bytes,
    output logic                       o_replacement,
    output logic [dmc_pkg::TAG_W-1:0]  o_evicted_tag
);
    import dmc_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencing of clear, capture and commit.
    dmc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    // Address split, tag store and result register.
    dmc_datapath #(
        .NUM_LINES   (NUM_LINES),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .i_address         (i_address),
        .i_opcode          (i_opcode),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_byte_offset     (o_byte_offset),
        .o_block_number    (o_block_number),
        .o_line_index      (o_line_index),
        .o_address_tag     (o_address_tag),
        .o_miss            (o_miss),
        .o_mem_read        (o_mem_read),
        .o_mem_read_bytes  (o_mem_read_bytes),
        .o_mem_write       (o_mem_write),
        .o_mem_write_bytes (o_mem_write_bytes),
        .o_replacement     (o_replacement),
        .o_evicted_tag     (o_evicted_tag)
    );

endmodule
